FILE: rtl/set_assoc_lru_hit_check_assert.svh
// Assertion macros shared by the checker of the set-associative tag store.
`ifndef SET_ASSOC_LRU_HIT_CHECK_ASSERT_SVH
`define SET_ASSOC_LRU_HIT_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SACHK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sachk: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SACHK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sachk: next-cycle check failed");

`endif

FILE: rtl/sachk_pkg.sv
// Types and constants of the set-associative tag store with LRU replacement.
`default_nettype none

package sachk_pkg;

  localparam int NUM_SETS    = 2;
  localparam int TOTAL_LINES = 4;
  localparam int WAYS        = TOTAL_LINES / NUM_SETS;

  localparam int TAG_W   = 16;
  localparam int STAMP_W = 32;
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // An untouched way holds the all-ones tag and a zero stamp, which marks it empty.
  localparam way_t RESET_WAY = '{tag: '1, stamp: '0};
  localparam row_t RESET_ROW = {WAYS{RESET_WAY}};

  localparam logic [STAMP_W-1:0] COUNTER_INIT = STAMP_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/sachk_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module sachk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/set_assoc_lru_hit_check.sv
// Set-associative cache tag store with LRU replacement: one lookup per address.
//
// An address is taken at a rising edge where start is high and busy is low. The set row
// (all ways' tags and use stamps) is read from a RAM with a registered read port; in
// the next cycle busy is high while the row is checked for a hit, an empty way or the
// least recently used way, and written back. The result appears with done_o for exactly
// one cycle, registered from the lookup state, and the receiver cannot hold it off. A new
// address may be started in the same cycle that the result is shown; busy holds off a new
// address only while the set row is checked and written back. Rows never written since
// reset read as empty through per-set valid flops, so no clearing pass runs.
`default_nettype none

module set_assoc_lru_hit_check (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [sachk_pkg::TAG_W-1:0]  address_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic                              set_index_o,
  output logic                              way_index_o
);

  sachk_pkg::state_e st_q, st_d;

  logic [sachk_pkg::TAG_W-1:0]   addr_q;
  logic [sachk_pkg::NUM_SETS-1:0] row_vld_q;
  logic                          rd_vld_q;
  logic [sachk_pkg::STAMP_W-1:0] cnt_q, cnt_d;
  logic                          done_q, hit_q, set_out_q, way_out_q;

  logic                          accept;
  logic                          lookup;
  logic [sachk_pkg::SET_W-1:0]   rd_set;
  logic [sachk_pkg::SET_W-1:0]   cur_set;
  logic [sachk_pkg::ROW_W-1:0]   rd_data;
  sachk_pkg::row_t               row;
  sachk_pkg::row_t               new_row;
  logic                          found;
  logic                          found_hit;
  logic [sachk_pkg::WAY_W-1:0]   found_way;
  logic [sachk_pkg::WAY_W-1:0]   victim;
  logic [sachk_pkg::WAY_W-1:0]   way_sel;

  assign accept  = start && !busy;
  assign lookup  = (st_q == sachk_pkg::ST_LOOKUP);
  // The set count is a power of two, so the modulo is the low address bits.
  assign rd_set  = address_i[sachk_pkg::SET_W-1:0];
  assign cur_set = addr_q[sachk_pkg::SET_W-1:0];

  sachk_ram #(
    .WIDTH (sachk_pkg::ROW_W),
    .DEPTH (sachk_pkg::NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (lookup),
    .waddr_i (cur_set),
    .wdata_i (new_row),
    .re_i    (accept),
    .raddr_i (rd_set),
    .rdata_o (rd_data)
  );

  always_comb begin
    st_d = st_q;
    busy = 1'b0;
    case (st_q)
      sachk_pkg::ST_IDLE: begin
        if (accept) begin
          st_d = sachk_pkg::ST_LOOKUP;
        end
      end
      sachk_pkg::ST_LOOKUP: begin
        busy = 1'b1;
        st_d = sachk_pkg::ST_IDLE;
      end
      default: begin
        st_d = sachk_pkg::ST_IDLE;
      end
    endcase
  end

  // Scan downward so the lowest way that is either empty or a valid match wins.
  always_comb begin
    row       = rd_vld_q ? sachk_pkg::row_t'(rd_data) : sachk_pkg::RESET_ROW;
    found     = 1'b0;
    found_hit = 1'b0;
    found_way = '0;
    for (int w = sachk_pkg::WAYS - 1; w >= 0; w--) begin
      if (row[w].stamp == '0) begin
        found     = 1'b1;
        found_hit = 1'b0;
        found_way = sachk_pkg::WAY_W'(w);
      end else if (row[w].tag == addr_q) begin
        found     = 1'b1;
        found_hit = 1'b1;
        found_way = sachk_pkg::WAY_W'(w);
      end
    end
  end

  // Least stamp in a full set; ties keep the lower way.
  always_comb begin
    victim = '0;
    for (int w = 1; w < sachk_pkg::WAYS; w++) begin
      if (row[w].stamp < row[victim].stamp) begin
        victim = sachk_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    way_sel               = found ? found_way : victim;
    new_row               = row;
    new_row[way_sel].tag   = addr_q;
    new_row[way_sel].stamp = cnt_q;
    cnt_d                 = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= sachk_pkg::ST_IDLE;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      cnt_q     <= sachk_pkg::COUNTER_INIT;
      done_q    <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= lookup;
      if (accept) begin
        rd_vld_q <= row_vld_q[rd_set];
      end
      if (lookup) begin
        row_vld_q[cur_set] <= 1'b1;
        cnt_q              <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= address_i;
    end
    if (lookup) begin
      hit_q     <= found && found_hit;
      set_out_q <= cur_set[0];
      way_out_q <= way_sel[0];
    end
  end

  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign set_index_o = set_out_q;
  assign way_index_o = way_out_q;

endmodule

`default_nettype wire

FILE: rtl/sachk_checker.sv
// Port-level checker for the set-associative tag store, bound to the top level.
`default_nettype none

`include "set_assoc_lru_hit_check_assert.svh"

module sachk_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [sachk_pkg::TAG_W-1:0] address_i,
  input wire logic                        done_o,
  input wire logic                        hit_o,
  input wire logic                        set_index_o,
  input wire logic                        way_index_o
);

  // Every transfer is followed by exactly one busy cycle and then its result.
  `SACHK_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SACHK_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && done_o)
  `SACHK_ASSERT_NOW(a_done_after_busy, done_o, $past(busy))
  // The reported set comes from the low bit of the address taken at its transfer.
  `SACHK_ASSERT_NOW(a_set_matches, done_o, set_index_o == $past(address_i[0], 2))
  // A strobed result never carries unknown bits.
  `SACHK_ASSERT_NOW(a_result_known, done_o, !$isunknown({hit_o, set_index_o, way_index_o}))

endmodule

bind set_assoc_lru_hit_check sachk_checker u_sachk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .address_i   (address_i),
  .done_o      (done_o),
  .hit_o       (hit_o),
  .set_index_o (set_index_o),
  .way_index_o (way_index_o)
);

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench of the set-associative tag store with LRU replacement.
`timescale 1ns / 100ps

module tb_top;

  localparam int N_RANDOM   = 2000;
  localparam int TAIL_WAIT  = 10;
  localparam int DRAIN_SPIN = 1000;

  typedef struct {
    logic [sachk_pkg::TAG_W-1:0] addr;
    int unsigned                 gap;
    bit                          drain;
  } lookup_req_t;

  typedef struct packed {
    logic hit;
    logic set_idx;
    logic way_idx;
  } lookup_res_t;

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        start     = 1'b0;
  logic [sachk_pkg::TAG_W-1:0] address_i = '0;
  logic                        busy;
  logic                        done_o;
  logic                        hit_o;
  logic                        set_index_o;
  logic                        way_index_o;

  lookup_req_t pending_q[$];
  lookup_res_t lookup_exp_q[$];

  // Shadow copy of the tag store, kept in step with every accepted address.
  logic [sachk_pkg::TAG_W-1:0]   line_tag[sachk_pkg::TOTAL_LINES];
  logic [sachk_pkg::STAMP_W-1:0] line_stamp[sachk_pkg::TOTAL_LINES];
  logic [sachk_pkg::STAMP_W-1:0] use_count;

  int unsigned n_errors  = 0;
  int unsigned n_sent    = 0;
  int unsigned n_results = 0;
  int unsigned n_hits    = 0;

  set_assoc_lru_hit_check uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .address_i   (address_i),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .set_index_o (set_index_o),
    .way_index_o (way_index_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic add_lookup(input logic [sachk_pkg::TAG_W-1:0] addr, input int unsigned gap,
                            input bit drain);
    lookup_req_t req;
    req.addr  = addr;
    req.gap   = gap;
    req.drain = drain;
    pending_q.push_back(req);
  endtask

  function automatic lookup_res_t predict_lookup(input logic [sachk_pkg::TAG_W-1:0] addr);
    int unsigned set_sel;
    int unsigned base;
    int unsigned way;
    int unsigned w;
    bit          hit;
    bit          placed;
    lookup_res_t res;
    set_sel = addr % sachk_pkg::NUM_SETS;
    base    = set_sel * sachk_pkg::WAYS;
    way     = 0;
    hit     = 1'b0;
    placed  = 1'b0;
    if (sachk_pkg::WAYS > 0) begin
      // Only a way with a nonzero stamp holds a live tag; the first empty way wins otherwise.
      for (w = 0; w < sachk_pkg::WAYS && !placed; w++) begin
        if (line_stamp[base + w] != '0) begin
          if (line_tag[base + w] == addr) begin
            hit    = 1'b1;
            placed = 1'b1;
            way    = w;
          end
        end else begin
          placed = 1'b1;
          way    = w;
        end
      end
      if (!placed) begin
        way = 0;
        for (w = 1; w < sachk_pkg::WAYS; w++) begin
          if (line_stamp[base + w] < line_stamp[base + way]) way = w;
        end
      end
      line_tag[base + way]   = addr;
      line_stamp[base + way] = use_count;
    end
    if (use_count != '1) use_count = use_count + 1'b1;
    res.hit     = hit;
    res.set_idx = set_sel[0];
    res.way_idx = way[0];
    return res;
  endfunction

  // Driver: presents queued addresses and records the expectation of each transfer.
  always @(posedge clk_i) begin : drive_proc
    lookup_req_t req;
    if (rst_ni) begin
      if (start && !busy) begin
        lookup_exp_q.push_back(predict_lookup(address_i));
        n_sent++;
      end
      if (!start || !busy) begin
        if (pending_q.size() == 0) begin
          start <= 1'b0;
        end else if (pending_q[0].gap != 0) begin
          pending_q[0].gap = pending_q[0].gap - 1;
          start <= 1'b0;
        end else if (pending_q[0].drain && lookup_exp_q.size() != 0) begin
          start <= 1'b0;
        end else begin
          req = pending_q.pop_front();
          address_i <= req.addr;
          start     <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin : monitor_proc
    lookup_res_t exp_res;
    if (rst_ni && done_o) begin
      n_results++;
      if (lookup_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result hit=%b set=%b way=%b",
                                  hit_o, set_index_o, way_index_o));
      end else begin
        exp_res = lookup_exp_q.pop_front();
        if (exp_res.hit) n_hits++;
        if (hit_o !== exp_res.hit)
          report_mismatch($sformatf("result %0d hit %b, expected %b",
                                    n_results, hit_o, exp_res.hit));
        if (set_index_o !== exp_res.set_idx)
          report_mismatch($sformatf("result %0d set %b, expected %b",
                                    n_results, set_index_o, exp_res.set_idx));
        if (way_index_o !== exp_res.way_idx)
          report_mismatch($sformatf("result %0d way %b, expected %b",
                                    n_results, way_index_o, exp_res.way_idx));
      end
    end
  end

  initial begin : main_proc
    logic [sachk_pkg::TAG_W-1:0] pool[6];
    int unsigned                 pool_n;
    int unsigned                 pick;
    int unsigned                 gap;
    int unsigned                 spin;
    bit                          quiet;
    logic [sachk_pkg::TAG_W-1:0] addr;

    for (int i = 0; i < sachk_pkg::TOTAL_LINES; i++) begin
      line_tag[i]   = '1;
      line_stamp[i] = '0;
    end
    use_count = sachk_pkg::COUNTER_INIT;

    // The all-ones address must miss on an empty way even though the reset tag matches it.
    add_lookup(16'hFFFF, 0, 1'b0);
    add_lookup(16'hFFFF, 0, 1'b0);
    add_lookup(16'h0000, 1, 1'b0);
    add_lookup(16'h0000, 0, 1'b0);
    add_lookup(16'hFFFD, 0, 1'b0);
    add_lookup(16'hFFFF, 2, 1'b0);
    add_lookup(16'h0002, 0, 1'b0);
    add_lookup(16'h0004, 0, 1'b0);
    add_lookup(16'h0000, 3, 1'b0);
    add_lookup(16'h0004, 0, 1'b0);
    add_lookup(16'hFFFD, 0, 1'b0);
    add_lookup(16'h8001, 0, 1'b0);
    add_lookup(16'hFFFF, 0, 1'b0);
    add_lookup(16'h7FFF, 5, 1'b0);
    add_lookup(16'hAAAA, 0, 1'b0);
    add_lookup(16'h5555, 0, 1'b0);
    add_lookup(16'h8000, 0, 1'b0);
    add_lookup(16'hAAAA, 14, 1'b0);
    add_lookup(16'h5555, 0, 1'b1);
    add_lookup(16'h8000, 0, 1'b0);

    // Random part: small working sets so that hits, fills and evictions all occur.
    pool_n = 1;
    quiet  = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) begin
        pool_n = $urandom_range(2, 6);
        for (int k = 0; k < 6; k++) pool[k] = sachk_pkg::TAG_W'($urandom);
        quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) addr = pool[$urandom_range(0, pool_n - 1)];
      else addr = sachk_pkg::TAG_W'($urandom);
      if (quiet || $urandom_range(0, 1) == 0) gap = 0;
      else gap = $urandom_range(0, 14);
      add_lookup(addr, gap, (i % 400) == 399);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start) @(posedge clk_i);
    spin = 0;
    while (lookup_exp_q.size() != 0 && spin < DRAIN_SPIN) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (lookup_exp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", lookup_exp_q.size()));

    $display("run: %0d addresses transferred, %0d results checked, %0d hits, %0d misses",
             n_sent, n_results, n_hits, n_results - n_hits);
    $display("run: directed corner addresses, random working sets, gaps and drain pauses");
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #5_000_000;
    $display("timeout after %0d transfers", n_sent);
    $display("tb_top: errors");
    $finish;
  end

endmodule
